@@ sv/gfmd_pkg.sv @@
// ----------------------------------------------------------------------------
// gfmd_pkg
// Shared constants and the segment decode for the gated frequency meter.
// ----------------------------------------------------------------------------
`default_nettype none

package gfmd_pkg;

  // Default number of scanned display digits
  localparam int DigitCountDef = 8;

  // Decimal digits needed for a 16-bit count (65535)
  localparam int BcdDigits = 5;

  // Gate length after reset, in scan ticks
  localparam logic [15:0] GateReset = 16'd500;

  typedef logic [3:0] digit_code_t;

  localparam digit_code_t CodeBlank = 4'd10;
  localparam digit_code_t CodeDash  = 4'd11;

  // Active-low segment pattern (point in bit 7) for a digit code
  function automatic logic [7:0] seg_pattern(digit_code_t code);
    logic [7:0] pat;
    case (code)
      4'd0:      pat = 8'hc0;
      4'd1:      pat = 8'hf9;
      4'd2:      pat = 8'ha4;
      4'd3:      pat = 8'hb0;
      4'd4:      pat = 8'h99;
      4'd5:      pat = 8'h92;
      4'd6:      pat = 8'h82;
      4'd7:      pat = 8'hf8;
      4'd8:      pat = 8'h80;
      4'd9:      pat = 8'h90;
      CodeBlank: pat = 8'hff;
      CodeDash:  pat = 8'hbf;
      default:   pat = 8'hff;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

@@ sv/gated_frequency_meter_display.sv @@
// ----------------------------------------------------------------------------
// gated_frequency_meter_display
// Counts pulse edges over a window of scan ticks and drives a multiplexed
// seven-segment display with the last latched count.
//
//   channel  | dir | handshake                 | payload
//   ---------+-----+---------------------------+-------------------------------
//   s_axis   | in  | s_axis_tvalid_i/tready_o  | tdata: pulse_edge, scan_tick
//   m_axis   | out | m_axis_tvalid_o/tready_i  | tdata: segments, enable, count
//            |     |                           | tlast: window_done
//   cfg      | in  | cfg_we_i                  | cfg_wdata_i: gate_ticks
//
// One item per clock while s_axis_tready_o is high; a result is registered.
// s_axis_tready_o is high while the output register is empty or being taken,
// so an item enters in the same cycle that a waiting result leaves.
// An item without scan_tick updates the pulse count and yields no result.
// The count is kept in binary and in decimal side by side, so a closing
// tick loads the digit buffer in the same cycle. Reset is asynchronous.
// ----------------------------------------------------------------------------
`default_nettype none

module gated_frequency_meter_display
  import gfmd_pkg::*;
#(
  parameter int DigitCount = DigitCountDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [0] pulse_edge, [1] scan_tick
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [7:0] segment_pattern, [15:8] digit_enable, [31:16] measured_count
  output logic [31:0]      m_axis_tdata_o,
  output logic             m_axis_tlast_o,   // window_done
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i       // gate_ticks
);

  localparam int PosW = $clog2(DigitCount);

  logic [15:0]        gate_q;
  logic [15:0]        pulse_q, pulse_d;
  logic [15:0]        tick_q, tick_inc;
  logic [PosW-1:0]    pos_q, pos_next;
  logic [15:0]        meas_q;
  digit_code_t        bcd_q [BcdDigits];
  digit_code_t        bcd_d [BcdDigits];
  digit_code_t        codes_q [DigitCount];
  digit_code_t        codes_new [DigitCount];
  digit_code_t        bcd_ext [8];
  logic [7:0]         show_ext;
  logic               carry;

  logic               in_acc, edge_hit, tick_hit, close;

  logic               out_valid_q;
  logic [7:0]         seg_q, en_q;
  logic               done_q;
  logic [15:0]        cnt_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign edge_hit = in_acc && s_axis_tdata_i[0];
  assign tick_hit = in_acc && s_axis_tdata_i[1];

  assign tick_inc = tick_q + 16'd1;
  assign close    = tick_hit && (tick_inc >= gate_q);
  assign pos_next = (pos_q == PosW'(DigitCount - 1)) ? '0 : pos_q + PosW'(1);

  // Pulse count, binary and decimal, including an edge of this cycle
  always_comb begin
    pulse_d = pulse_q;
    carry   = 1'b0;
    for (int i = 0; i < BcdDigits; i++) begin
      bcd_d[i] = bcd_q[i];
    end
    if (edge_hit) begin
      pulse_d = pulse_q + 16'd1;
      if (pulse_q == 16'hffff) begin
        // binary wraps to zero: restart the decimal copy as well
        for (int i = 0; i < BcdDigits; i++) begin
          bcd_d[i] = 4'd0;
        end
      end else begin
        carry = 1'b1;
        for (int i = 0; i < BcdDigits; i++) begin
          if (carry) begin
            if (bcd_q[i] == 4'd9) begin
              bcd_d[i] = 4'd0;
            end else begin
              bcd_d[i] = bcd_q[i] + 4'd1;
              carry    = 1'b0;
            end
          end
        end
      end
    end
  end

  // Right-aligned digit codes for a closing window, a dash in position 0, leading zeros blank
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      bcd_ext[i] = 4'd0;
    end
    for (int i = 0; i < BcdDigits; i++) begin
      bcd_ext[i] = bcd_d[i];
    end
    show_ext = '0;
    for (int i = BcdDigits - 1; i >= 0; i--) begin
      show_ext[i] = show_ext[i+1] || (bcd_d[i] != 4'd0);
    end
    for (int p = 0; p < DigitCount; p++) begin
      if (p == 0) begin
        codes_new[p] = CodeDash;
      end else if (show_ext[3'(DigitCount - 1 - p)]) begin
        codes_new[p] = bcd_ext[3'(DigitCount - 1 - p)];
      end else begin
        codes_new[p] = CodeBlank;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q  <= GateReset;
      pulse_q <= '0;
      tick_q  <= '0;
      pos_q   <= '0;
      meas_q  <= '0;
      for (int i = 0; i < BcdDigits; i++) begin
        bcd_q[i] <= 4'd0;
      end
      for (int p = 0; p < DigitCount; p++) begin
        codes_q[p] <= CodeBlank;
      end
    end else begin
      if (cfg_we_i) begin
        gate_q <= cfg_wdata_i;
      end
      if (close) begin
        // latch the window and restart the counts
        meas_q  <= pulse_d;
        pulse_q <= '0;
        tick_q  <= '0;
        for (int i = 0; i < BcdDigits; i++) begin
          bcd_q[i] <= 4'd0;
        end
        for (int p = 0; p < DigitCount; p++) begin
          codes_q[p] <= codes_new[p];
        end
      end else begin
        pulse_q <= pulse_d;
        for (int i = 0; i < BcdDigits; i++) begin
          bcd_q[i] <= bcd_d[i];
        end
        if (tick_hit) begin
          tick_q <= tick_inc;
        end
      end
      if (tick_hit) begin
        pos_q <= pos_next;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= tick_hit;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_hit) begin
      seg_q  <= seg_pattern(codes_q[pos_q]);
      en_q   <= 8'd1 << pos_q;
      done_q <= close;
      cnt_q  <= close ? pulse_d : meas_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {cnt_q, en_q, seg_q};
  assign m_axis_tlast_o  = done_q;

`ifndef SYNTH
  a_enable_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> $onehot(m_axis_tdata_o[15:8]))
    else $error("digit enable not one-hot");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) < DigitCount)
    else $error("scan position beyond digit count");

  a_close_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    close |=> m_axis_tvalid_o && m_axis_tlast_o && (tick_q == 16'd0))
    else $error("closed window not flagged or tick count not cleared");

  a_no_tick_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !s_axis_tdata_i[1] |=> !m_axis_tvalid_o)
    else $error("result without scan tick");

  a_digit0_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (codes_q[0] == CodeBlank) || (codes_q[0] == CodeDash))
    else $error("digit 0 holds a numeric code");
`endif

endmodule

`default_nettype wire
